// ===== rtl/core/mro_pkg.sv =====
// Shared constants, types and helpers for the max rectangle of ones block.
`default_nettype none

package mro_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;

  // Fixed field widths
  localparam int COUNT_W     = 7;
  localparam int AREA_W      = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int AREA_LIMIT  = (1 << AREA_W) - 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

  // Derived widths
  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HEIGHT_W = $clog2(MAX_ROWS + 1);
  localparam int POS_W    = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_BASE = (POS_W > HEIGHT_W) ? POS_W : HEIGHT_W;
  localparam int CMP_W    = ((CMP_BASE > COUNT_W) ? CMP_BASE : COUNT_W) + 1;
  localparam int PROD_W   = (HEIGHT_W + POS_W > AREA_W) ? HEIGHT_W + POS_W : AREA_W + 1;
  localparam int AREA_CAP = (MAX_ROWS * MAX_COLUMNS > AREA_LIMIT) ? AREA_LIMIT
                                                                  : MAX_ROWS * MAX_COLUMNS;

  // One histogram stack entry: left edge of the bar's span and its height
  typedef struct packed {
    logic [COL_W-1:0]    left;
    logic [HEIGHT_W-1:0] height;
  } stack_entry_t;

  // Zero acts as one, anything above the maximum saturates to it
  function automatic logic [CMP_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                   input logic [CMP_W-1:0]   maxv);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (v == '0) begin
      return CMP_W'(1);
    end else if (wide > maxv) begin
      return maxv;
    end
    return wide;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/max_rectangle_of_ones_top.sv =====
// Max rectangle of ones: streamed binary matrix in, largest all-ones rectangle area out.
`default_nettype none

// Cells arrive one word at a time in row-major order; row_count and column_count
// (zero acts as one, above 64 saturates) set the matrix shape. For each cell its
// column height is read from the height memory and then written back. The last
// cell of a row then runs a stack scan of the height histogram on a single shared
// multiply/compare datapath: each column passes through a load and a compare step,
// and each stack pop adds a pop step. After the last row the area is loaded into
// the output register as the matrix state clears; the next cell can be taken
// while that result waits. If a previous result is still not taken, the block
// holds at the end of the matrix until it is. Register writes are taken only
// while the block waits for a cell, and a pending write holds off the cell word.
module max_rectangle_of_ones_top
  import mro_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cell_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [AREA_W-1:0]      max_area
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CELL = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_END  = 3'd5;

  logic [2:0]          state;
  logic [COUNT_W-1:0]  row_count;
  logic [COUNT_W-1:0]  column_count;
  logic [COL_W-1:0]    column_index;
  logic [ROW_W-1:0]    row_index;
  logic [AREA_W-1:0]   best_area;
  logic                cell_bit;

  logic [HEIGHT_W-1:0]    height_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] height_vld;
  logic [HEIGHT_W-1:0]    height_rd;
  logic                   height_rd_vld;

  stack_entry_t        stack_mem [MAX_COLUMNS];
  stack_entry_t        stack_rd;
  stack_entry_t        top;
  logic [POS_W-1:0]    depth;
  logic [POS_W-1:0]    pos;
  logic [COL_W-1:0]    push_left;
  logic [PROD_W-1:0]   area_reg;

  logic [CMP_W-1:0]    rows_eff;
  logic [CMP_W-1:0]    cols_eff;
  logic                rd_en;
  logic [COL_W-1:0]    rd_addr;
  logic [HEIGHT_W-1:0] height_cur;
  logic [HEIGHT_W-1:0] height_next;
  logic                col_last;
  logic                row_last;
  logic                pos_live;
  logic [HEIGHT_W-1:0] scan_cur;
  logic                pop;
  logic                push;
  stack_entry_t        push_entry;
  logic [POS_W-1:0]    span;
  logic [PROD_W-1:0]   product;
  logic [POS_W-1:0]    depth_m2;
  logic [AREA_W-1:0]   area_sat;
  logic                out_free;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  assign rows_eff = clamp_count(row_count, CMP_W'(MAX_ROWS));
  assign cols_eff = clamp_count(column_count, CMP_W'(MAX_COLUMNS));

  // Cell update: read height at the current column, then write it back
  assign rd_en   = (in_valid && in_ready) || (state == S_LOAD);
  assign rd_addr = (state == S_IDLE) ? column_index : pos[COL_W-1:0];

  assign height_cur  = height_rd_vld ? height_rd : '0;
  assign height_next = !cell_bit ? '0 :
                       (height_cur < HEIGHT_W'(MAX_ROWS)) ? height_cur + HEIGHT_W'(1)
                                                          : height_cur;
  assign col_last = (CMP_W'(column_index) + CMP_W'(1)) >= cols_eff;
  assign row_last = (CMP_W'(row_index) + CMP_W'(1)) >= rows_eff;

  // Histogram scan; the position past the last column acts as a zero bar
  assign pos_live = CMP_W'(pos) < cols_eff;
  assign scan_cur = pos_live ? height_cur : '0;
  assign pop      = (state == S_CMP) && (depth != '0) && (top.height >= scan_cur);
  assign push     = (state == S_CMP) && !pop && pos_live;

  assign push_entry.left   = push_left;
  assign push_entry.height = scan_cur;

  assign span     = pos - POS_W'(top.left);
  assign product  = PROD_W'(top.height) * PROD_W'(span);
  assign depth_m2 = depth - POS_W'(2);
  assign area_sat = (area_reg > PROD_W'(AREA_LIMIT)) ? AREA_W'(AREA_LIMIT)
                                                     : area_reg[AREA_W-1:0];
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      height_rd     <= height_mem[rd_addr];
      height_rd_vld <= height_vld[rd_addr];
    end
    if (state == S_CELL) begin
      height_mem[column_index] <= height_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[depth[COL_W-1:0]] <= push_entry;
    end
    if (pop) begin
      stack_rd <= stack_mem[depth_m2[COL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= COUNT_W'(64);
      column_count <= COUNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_index <= '0;
      row_index    <= '0;
      best_area    <= '0;
      height_vld   <= '0;
      depth        <= '0;
      pos          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_END && row_last && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cell_bit <= cell_req;
            state    <= S_CELL;
          end
        end
        S_CELL: begin
          height_vld[column_index] <= 1'b1;
          if (col_last) begin
            column_index <= '0;
            pos          <= '0;
            depth        <= '0;
            state        <= S_LOAD;
          end else begin
            column_index <= column_index + COL_W'(1);
            state        <= S_IDLE;
          end
        end
        S_LOAD: begin
          push_left <= pos[COL_W-1:0];
          state     <= S_CMP;
        end
        S_CMP: begin
          if (pop) begin
            area_reg  <= product;
            push_left <= top.left;
            depth     <= depth - POS_W'(1);
            state     <= S_POP;
          end else if (pos_live) begin
            top   <= push_entry;
            depth <= depth + POS_W'(1);
            pos   <= pos + POS_W'(1);
            state <= S_LOAD;
          end else begin
            state <= S_END;
          end
        end
        S_POP: begin
          top <= stack_rd;
          if (area_sat > best_area) begin
            best_area <= area_sat;
          end
          state <= S_CMP;
        end
        S_END: begin
          if (!row_last) begin
            row_index <= row_index + ROW_W'(1);
            state     <= S_IDLE;
          end else if (out_free) begin
            // deliver the area and clear the matrix
            max_area   <= best_area;
            best_area  <= '0;
            row_index  <= '0;
            height_vld <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (depth <= pos))
    else $error("scan stack deeper than columns scanned");

  a_accept_to_cell: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CELL))
    else $error("accepted word did not start a cell update");

  a_best_tracks_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (best_area >= $past(area_sat)))
    else $error("best area lost a popped rectangle");

  a_area_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (max_area <= AREA_W'(AREA_CAP)))
    else $error("area exceeds matrix size");
`endif

endmodule

`default_nettype wire
